// ===== sv/stps_pkg.sv =====
// Package for the segmented three-point smoother: widths, register indexes,
// reset values, the result entry type and the divide-by-three helper.
// Used by segmented_three_point_smoother_core and stps_checker.
`default_nettype none

package stps_pkg;

    localparam int DIST_WIDTH     = 16;
    localparam int ANGLE_WIDTH    = 13;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_IDX_WIDTH  = 1;

    // Sum of three distances and the pair sum kept in state.
    localparam int SUM_WIDTH  = DIST_WIDTH + 2;
    localparam int PAIR_WIDTH = DIST_WIDTH + 1;

    // Reciprocal of three, rounded up, scaled by 2**RECIP_SHIFT. With one extra
    // bit of scale the error stays below one third over the whole sum range,
    // so the truncated product equals the truncated quotient.
    localparam int RECIP_SHIFT = SUM_WIDTH + 1;
    localparam int RECIP_WIDTH = SUM_WIDTH;
    localparam logic [RECIP_WIDTH-1:0] RECIP_THIRD =
        RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);

    localparam logic [CFG_DATA_WIDTH-1:0] DIST_LIMIT_RESET  = 16'd200;
    localparam logic [ANGLE_WIDTH-1:0]    ANGLE_LIMIT_RESET = 13'd2540;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_DIST_LIMIT  = 1'b0,
        CFG_ANGLE_LIMIT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] smoothed;
        logic                  last;
    } result_t;

    function automatic logic [DIST_WIDTH-1:0] div_by_three(
        input logic [SUM_WIDTH-1:0] x
    );
        logic [SUM_WIDTH+RECIP_WIDTH-1:0] prod;
        prod = {{RECIP_WIDTH{1'b0}}, x} * {{SUM_WIDTH{1'b0}}, RECIP_THIRD};
        return prod[RECIP_SHIFT +: DIST_WIDTH];
    endfunction

endpackage

`default_nettype wire

// ===== sv/segmented_three_point_smoother_core.sv =====
// Segmented three-point smoother for the distance samples of a lidar scan.
// Top level: input register, run tracking, averaging and a two-entry result
// buffer. Depends on stps_pkg.
//
// Usage:
//   Samples (distance_mm, angle_mrad, scan_end) enter on the in_valid/in_ready
//   channel; smoothed distances leave on out_valid/out_ready with last_of_scan
//   set on the final result of a scan's last sample. One request causes zero,
//   one or two results.
//   A request is held in the input register and processed once the result
//   buffer is empty or drains its single entry in that cycle; its results
//   are then visible from the following cycle.
//   Throughput is one sample per cycle while out_ready is high and no sample
//   causes two results; the next waits for a second result to be taken. The
//   rate is set by the single output port of the two-entry result buffer.
//   When the receiver stalls, the buffer holds its results unchanged and
//   in_ready drops once the input register is also full. Reset clears the
//   run count and stored samples, returns both limits to their defaults
//   (200 mm, 2540 mrad) and empties all stages. The user must write limits
//   through cfg_we/cfg_index/cfg_data while the block is idle; unenforced.
`default_nettype none

module segmented_three_point_smoother_core
    import stps_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data,

    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [DIST_WIDTH-1:0]     distance_mm,
    input  wire logic [ANGLE_WIDTH-1:0]    angle_mrad,
    input  wire logic                      scan_end,

    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [DIST_WIDTH-1:0]          smoothed_mm,
    output logic                           last_of_scan
);

    // Configuration.
    logic [CFG_DATA_WIDTH-1:0] dist_limit_reg;
    logic [ANGLE_WIDTH-1:0]    angle_limit_reg;

    // Input register.
    logic                   a_valid_reg;
    logic [DIST_WIDTH-1:0]  a_dist_reg;
    logic [ANGLE_WIDTH-1:0] a_angle_reg;
    logic                   a_end_reg;

    // Run state.
    logic [DIST_WIDTH-1:0]  prev_dist_reg, prev_dist_next;
    logic [PAIR_WIDTH-1:0]  pair_sum_reg, pair_sum_next;
    logic [ANGLE_WIDTH-1:0] prev_angle_reg, prev_angle_next;
    logic [1:0]             run_count_reg, run_count_next;

    // Result buffer, entry 0 is the head.
    result_t    e0_reg, e0_next;
    result_t    e1_reg, e1_next;
    logic [1:0] count_reg, count_next;

    logic pop;
    logic room;
    logic consume;

    logic [1:0]             cnt;
    logic [DIST_WIDTH-1:0]  dist_step;
    logic [ANGLE_WIDTH-1:0] angle_step;
    logic                   jump;
    logic [SUM_WIDTH-1:0]   sum3;
    logic [DIST_WIDTH-1:0]  mean3;
    logic [1:0]             n_results;
    logic [DIST_WIDTH-1:0]  r0_dist, r1_dist;

    assign pop       = out_valid && out_ready;
    assign room      = (count_reg == 2'd0) || ((count_reg == 2'd1) && pop);
    assign consume   = a_valid_reg && room;
    assign in_ready  = !a_valid_reg || consume;

    assign out_valid    = (count_reg != 2'd0);
    assign smoothed_mm  = e0_reg.smoothed;
    assign last_of_scan = e0_reg.last;

    // Per-sample run logic.
    always_comb
    begin
        cnt        = (run_count_reg == 2'd3) ? 2'd3 : run_count_reg + 2'd1;
        dist_step  = (prev_dist_reg >= a_dist_reg) ? prev_dist_reg - a_dist_reg
                                                   : a_dist_reg - prev_dist_reg;
        angle_step = (prev_angle_reg >= a_angle_reg) ? prev_angle_reg - a_angle_reg
                                                     : a_angle_reg - prev_angle_reg;
        jump       = (cnt != 2'd1) &&
                     ((dist_step > dist_limit_reg) || (angle_step > angle_limit_reg));
        sum3       = SUM_WIDTH'(pair_sum_reg) + SUM_WIDTH'(a_dist_reg);
        mean3      = div_by_three(sum3);

        r0_dist        = a_dist_reg;
        r1_dist        = a_dist_reg;
        n_results      = 2'd0;
        run_count_next = cnt;

        if (cnt == 2'd1)
        begin
            n_results = 2'd1;
        end
        else if (jump)
        begin
            // A broken run flushes the held sample when it was being averaged.
            if (cnt == 2'd3)
            begin
                r0_dist   = prev_dist_reg;
                n_results = 2'd2;
            end
            else
            begin
                n_results = 2'd1;
            end
            run_count_next = 2'd0;
        end
        else if (cnt == 2'd3)
        begin
            r0_dist   = mean3;
            n_results = a_end_reg ? 2'd2 : 2'd1;
        end
        else
        begin
            n_results = a_end_reg ? 2'd1 : 2'd0;
        end

        if (a_end_reg)
        begin
            run_count_next = 2'd0;
        end

        prev_dist_next  = a_dist_reg;
        prev_angle_next = a_angle_reg;
        pair_sum_next   = PAIR_WIDTH'(prev_dist_reg) + PAIR_WIDTH'(a_dist_reg);
    end

    // Result buffer update. A sample is only taken when the buffer will be
    // empty, so its results always land at the head.
    always_comb
    begin
        e0_next    = e0_reg;
        e1_next    = e1_reg;
        count_next = count_reg;
        if (consume)
        begin
            e0_next.smoothed = r0_dist;
            e0_next.last     = a_end_reg && (n_results == 2'd1);
            e1_next.smoothed = r1_dist;
            e1_next.last     = a_end_reg;
            count_next       = n_results;
        end
        else if (pop)
        begin
            e0_next    = e1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_limit_reg  <= DIST_LIMIT_RESET;
            angle_limit_reg <= ANGLE_LIMIT_RESET;
            a_valid_reg     <= 1'b0;
            prev_dist_reg   <= '0;
            pair_sum_reg    <= '0;
            prev_angle_reg  <= '0;
            run_count_reg   <= 2'd0;
            count_reg       <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_DIST_LIMIT:  dist_limit_reg  <= cfg_data;
                    CFG_ANGLE_LIMIT: angle_limit_reg <= cfg_data[ANGLE_WIDTH-1:0];
                    default:         ;
                endcase
            end
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (consume)
            begin
                prev_dist_reg  <= prev_dist_next;
                pair_sum_reg   <= pair_sum_next;
                prev_angle_reg <= prev_angle_next;
                run_count_reg  <= run_count_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_dist_reg  <= distance_mm;
            a_angle_reg <= angle_mrad;
            a_end_reg   <= scan_end;
        end
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule

`default_nettype wire

// ===== sv/stps_checker.sv =====
// Port-level checker for segmented_three_point_smoother_core, attached by a
// bind statement at the end of this file. Depends on stps_pkg.
`default_nettype none

module stps_checker
    import stps_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [DIST_WIDTH-1:0]     smoothed_mm,
    input wire logic                      last_of_scan
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(smoothed_mm) &&
                                    $stable(last_of_scan))
        else $error("stalled result changed");

    // With no result pending, the block can always take a new request.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while no result is pending");

    // Nothing is presented in the first cycle after reset.
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result presented right after reset");

endmodule

bind segmented_three_point_smoother_core stps_checker u_stps_checker (.*);

`default_nettype wire
